FILE: rtl/core/pixel_mask_collision_test_unit_macros.svh
// Assertion macros for the pixel mask collision test unit.
// Expects signals clk and arst_n in the scope of use.
`ifndef PIXEL_MASK_COLLISION_TEST_UNIT_MACROS_SVH
`define PIXEL_MASK_COLLISION_TEST_UNIT_MACROS_SVH

// same-cycle implication
`define PMCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PMCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pmct_pkg.sv
// Shared types, constants and helpers for the pixel mask collision test unit.
// No dependencies.
`default_nettype none

package pmct_pkg;

	localparam int MAX_DIM = 64;
	localparam int AW      = $clog2(MAX_DIM);
	localparam int CW      = $clog2(MAX_DIM + 1);
	localparam int COL_W   = 64;
	localparam int SH_W    = $clog2(COL_W);
	localparam int DIM_W   = 7;
	localparam int POS_W   = 12;
	localparam int EXT_W   = 14;

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_TEST   = 2'd2;

	localparam logic [1:0] CFG_WIDTH_A  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT_A = 2'd1;
	localparam logic [1:0] CFG_WIDTH_B  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT_B = 2'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

	typedef struct packed {
		logic [1:0]              req_type;
		logic [5:0]              column_index;
		logic [COL_W-1:0]        column_bits;
		logic signed [POS_W-1:0] pos_a_x;
		logic signed [POS_W-1:0] pos_a_y;
		logic signed [POS_W-1:0] pos_b_x;
		logic signed [POS_W-1:0] pos_b_y;
	} pmct_req_t;

	typedef struct packed {
		logic hit;
		logic boxes_overlap;
	} pmct_rsp_t;

	typedef struct packed {
		logic accept;
		logic calc_box;
		logic calc_ovl;
		logic issue;
		logic result_load;
	} pmct_cmd_t;

	typedef struct packed {
		logic cols_done;
		logic out_free;
	} pmct_sts_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		return (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pixel_mask_collision_test_unit.sv
// Pixel-accurate collision test between two sprite masks held in column RAMs.
// A test runs from its transfer through the box math and a scan of the N overlap
// columns (0 to 64) until its result is registered: one column pair is read from
// the two mask RAMs and ANDed per cycle. Loads and tests are taken one at a time;
// a load may enter while a finished result still waits at the output. The user
// must write the size registers only while no test is in flight; the block
// itself does not enforce this.
// Depends on pmct_pkg, pmct_ctrl, pmct_dp, pmct_ram and the macros header.
`default_nettype none
`include "pixel_mask_collision_test_unit_macros.svh"

module pixel_mask_collision_test_unit
	import pmct_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire pmct_req_t        req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output pmct_rsp_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data
);

	pmct_cmd_t cmd;
	pmct_sts_t sts;

	pmct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pmct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`PMCT_ASSERT_NEXT(a_test_blocks_input, req_valid && !req_stall && (req.req_type == REQ_TEST), req_stall, "input not stalled after test transfer")
	`PMCT_ASSERT_NOW(a_load_needs_room, cmd.result_load, sts.out_free, "result loaded over a pending one")
	`PMCT_ASSERT_NOW(a_rsp_from_ctrl, $rose(rsp_valid), $past(cmd.result_load), "result valid without a load")
	`PMCT_ASSERT_NOW(a_hit_needs_overlap, rsp_valid && rsp.hit, rsp.boxes_overlap, "hit without box overlap")

endmodule

`default_nettype wire

FILE: rtl/core/pmct_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pmct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pmct_ctrl.sv
// Sequencer for the collision test: accept, box math, column scan, result.
// Depends on pmct_pkg.
`default_nettype none

module pmct_ctrl
	import pmct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_type,
	output logic            req_stall,
	input  wire pmct_sts_t  sts,
	output pmct_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CALC1 = 3'd1;
	localparam logic [2:0] ST_CALC2 = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_TEST) begin
						state_d = ST_CALC1;
					end
				end
			end
			ST_CALC1: begin
				cmd.calc_box = 1'b1;
				state_d      = ST_CALC2;
			end
			ST_CALC2: begin
				cmd.calc_ovl = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.cols_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pmct_dp.sv
// Datapath: size registers, mask RAMs, box overlap math, column AND scan,
// result register. Depends on pmct_pkg and pmct_ram.
`default_nettype none

module pmct_dp
	import pmct_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pmct_req_t        req,
	input  wire pmct_cmd_t        cmd,
	output pmct_sts_t             sts,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [DIM_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output pmct_rsp_t             rsp
);

	logic [DIM_W-1:0] wa_q, ha_q, wb_q, hb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= DIM_RESET;
			ha_q <= DIM_RESET;
			wb_q <= DIM_RESET;
			hb_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH_A:  wa_q <= cfg_data;
				CFG_HEIGHT_A: ha_q <= cfg_data;
				CFG_WIDTH_B:  wb_q <= cfg_data;
				CFG_HEIGHT_B: hb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// mask column stores
	logic             col_ok;
	logic             we_a, we_b;
	logic [AW-1:0]    ca_q, cb_q;
	logic [COL_W-1:0] rda, rdb;

	assign col_ok = ({1'b0, req.column_index} < 7'(MAX_DIM));
	assign we_a   = cmd.accept && (req.req_type == REQ_LOAD_A) && col_ok;
	assign we_b   = cmd.accept && (req.req_type == REQ_LOAD_B) && col_ok;

	pmct_ram #(.WIDTH(COL_W), .DEPTH(MAX_DIM)) u_mask_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (req.column_index[AW-1:0]),
		.wdata (req.column_bits),
		.re    (cmd.issue),
		.raddr (ca_q),
		.rdata (rda)
	);

	pmct_ram #(.WIDTH(COL_W), .DEPTH(MAX_DIM)) u_mask_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (req.column_index[AW-1:0]),
		.wdata (req.column_bits),
		.re    (cmd.issue),
		.raddr (cb_q),
		.rdata (rdb)
	);

	// positions and box edges
	logic signed [POS_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [EXT_W-1:0] ax, ay, bx, by;
	logic signed [EXT_W-1:0] wa_x, ha_x, wb_x, hb_x;
	logic signed [EXT_W-1:0] ar_q, ab_q, br_q, bb_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ax_q <= req.pos_a_x;
			ay_q <= req.pos_a_y;
			bx_q <= req.pos_b_x;
			by_q <= req.pos_b_y;
		end
	end

	assign ax   = EXT_W'(ax_q);
	assign ay   = EXT_W'(ay_q);
	assign bx   = EXT_W'(bx_q);
	assign by   = EXT_W'(by_q);
	assign wa_x = {{(EXT_W-DIM_W){1'b0}}, eff_dim(wa_q)};
	assign ha_x = {{(EXT_W-DIM_W){1'b0}}, eff_dim(ha_q)};
	assign wb_x = {{(EXT_W-DIM_W){1'b0}}, eff_dim(wb_q)};
	assign hb_x = {{(EXT_W-DIM_W){1'b0}}, eff_dim(hb_q)};

	always_ff @(posedge clk) begin
		if (cmd.calc_box) begin
			ar_q <= ax + wa_x;
			ab_q <= ay + ha_x;
			br_q <= bx + wb_x;
			bb_q <= by + hb_x;
		end
	end

	// overlap rectangle
	logic                    ovl;
	logic signed [EXT_W-1:0] left, right, top, bottom;
	logic signed [EXT_W-1:0] d_cols, d_rows, d_ca, d_cb, d_sa, d_sb;
	logic                    ovl_q;
	logic [CW-1:0]           cnt_q;
	logic [SH_W-1:0]         sha_q, shb_q;
	logic [COL_W-1:0]        mask_q;

	assign ovl    = !((ar_q < bx) || (ax > br_q) || (ay > bb_q) || (ab_q < by));
	assign left   = (ax > bx) ? ax : bx;
	assign right  = (ar_q < br_q) ? ar_q : br_q;
	assign top    = (ay > by) ? ay : by;
	assign bottom = (ab_q < bb_q) ? ab_q : bb_q;
	assign d_cols = right - left;
	assign d_rows = bottom - top;
	assign d_ca   = left - ax;
	assign d_cb   = left - bx;
	assign d_sa   = top - ay;
	assign d_sb   = top - by;

	always_ff @(posedge clk) begin
		if (cmd.calc_ovl) begin
			ovl_q  <= ovl;
			ca_q   <= d_ca[AW-1:0];
			cb_q   <= d_cb[AW-1:0];
			sha_q  <= d_sa[SH_W-1:0];
			shb_q  <= d_sb[SH_W-1:0];
			mask_q <= ~({COL_W{1'b1}} << d_rows[DIM_W-1:0]);
		end else if (cmd.issue) begin
			ca_q <= ca_q + AW'(1);
			cb_q <= cb_q + AW'(1);
		end
	end

	// scan control and hit accumulation
	logic rd_pend_s1;
	logic hit_q;
	logic col_hit;

	assign col_hit = |((rda >> sha_q) & (rdb >> shb_q) & mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.issue;
			if (cmd.calc_ovl) begin
				cnt_q <= (ovl && (d_rows > 0)) ? d_cols[CW-1:0] : '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					cnt_q <= cnt_q - CW'(1);
				end
				if (rd_pend_s1 && col_hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// result register
	logic      rsp_valid_q;
	pmct_rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			rsp_q.hit           <= hit_q & ovl_q;
			rsp_q.boxes_overlap <= ovl_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign sts.cols_done = (cnt_q == '0);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

endmodule

`default_nettype wire
